[design/uvls_pkg.sv]
package uvls_pkg;

  // Field widths
  localparam int unsigned VAL_W  = 31;
  localparam int unsigned IN_W   = 32;
  localparam int unsigned STAT_W = 3;

  // Command codes
  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_NEGATIVE  = 3'd1;
  localparam logic [STAT_W-1:0] ST_DUPLICATE = 3'd2;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd3;
  localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd4;

  // Shift control broadcast to every cell
  typedef struct packed {
    logic push;  // every cell takes the value of the cell above it
    logic pop;   // every cell but the bottom one takes the value of the cell below it
  } shift_ctl_t;

endpackage

[design/unique_value_lifo_stack.sv]
// LIFO stack of non-negative 31-bit values that refuses duplicates.
// Input channel: in_valid/in_stall with in_cmd (0 push, 1 pop) and the
// signed 32-bit in_push_value (ignored on pop). Result channel:
// out_valid/out_stall with out_result_value and out_status
// (0 ok, 1 negative, 2 duplicate, 3 full, 4 empty). Each item gives
// exactly one result.
// out_valid is registered and rises in the cycle after acceptance.
// Throughput: one item per cycle while in_stall is low; every stack cell
// compares its entry against the pushed value in the same cycle, and the
// chain shifts one place per successful push or pop. The top of the stack
// is cell 0; a push shifts all cells one place down, a pop shifts them one
// place up. Reset empties the stack (the count goes to zero) and drops any
// waiting result; cell contents are not cleared. While the receiver stalls
// a waiting result, in_stall is raised and no new item is taken, so the
// result holds steady until it is taken.
module unique_value_lifo_stack
  import uvls_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_cmd,
  input  logic [IN_W-1:0]   in_push_value,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [VAL_W-1:0]  out_result_value,
  output logic [STAT_W-1:0] out_status
);

  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  logic [CW-1:0]     count_r, count_nxt;
  logic              out_valid_r;
  logic [VAL_W-1:0]  out_value_r, out_value_nxt;
  logic [STAT_W-1:0] out_status_r, out_status_nxt;

  logic [VAL_W-1:0]       cell_val [STACK_DEPTH];
  logic [STACK_DEPTH-1:0] cell_match;
  logic [VAL_W-1:0]       cmp_value;
  shift_ctl_t             ctl;

  logic accept, is_push, negative, duplicate, full, empty;

  assign in_stall  = out_valid_r && out_stall;
  assign accept    = in_valid && !in_stall;
  assign is_push   = (in_cmd == CMD_PUSH);
  assign cmp_value = in_push_value[VAL_W-1:0];

  // Push checks in priority order: negative, duplicate, full
  assign negative  = in_push_value[IN_W-1];
  assign duplicate = |cell_match;
  assign full      = (count_r == CW'(STACK_DEPTH));
  assign empty     = (count_r == '0);

  always_comb begin
    ctl.push       = 1'b0;
    ctl.pop        = 1'b0;
    count_nxt      = count_r;
    out_value_nxt  = '0;
    out_status_nxt = ST_OK;
    if (is_push) begin
      if (negative) begin
        out_status_nxt = ST_NEGATIVE;
      end else if (duplicate) begin
        out_status_nxt = ST_DUPLICATE;
      end else if (full) begin
        out_status_nxt = ST_FULL;
      end else begin
        ctl.push      = accept;
        out_value_nxt = cmp_value;
        count_nxt     = count_r + CW'(1);
      end
    end else begin
      if (empty) begin
        out_status_nxt = ST_EMPTY;
      end else begin
        ctl.pop       = accept;
        out_value_nxt = cell_val[0];
        count_nxt     = count_r - CW'(1);
      end
    end
  end

  // Chain of cells, top of stack at index 0
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [VAL_W-1:0] above, below;
    if (i == 0) begin : g_top
      assign above = cmp_value;
    end else begin : g_mid
      assign above = cell_val[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_bot
      assign below = cell_val[i];
    end else begin : g_up
      assign below = cell_val[i+1];
    end
    uvls_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .occupied   (CW'(i) < count_r),
      .from_above (above),
      .from_below (below),
      .cmp_value  (cmp_value),
      .value      (cell_val[i]),
      .match      (cell_match[i])
    );
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (accept) begin
      out_value_r  <= out_value_nxt;
      out_status_r <= out_status_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = out_value_r;
  assign out_status       = out_status_r;

endmodule

[design/uvls_cell.sv]
module uvls_cell
  import uvls_pkg::*;
(
  input  logic             clk,
  input  shift_ctl_t       ctl,
  input  logic             occupied,
  input  logic [VAL_W-1:0] from_above,
  input  logic [VAL_W-1:0] from_below,
  input  logic [VAL_W-1:0] cmp_value,
  output logic [VAL_W-1:0] value,
  output logic             match
);

  logic [VAL_W-1:0] data_r;
  logic [VAL_W-1:0] data_nxt;

  // Shift toward the bottom on push, toward the top on pop
  always_comb begin
    if (ctl.push) begin
      data_nxt = from_above;
    end else if (ctl.pop) begin
      data_nxt = from_below;
    end else begin
      data_nxt = data_r;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  // Local duplicate check; only held entries take part
  assign match = occupied && (data_r == cmp_value);
  assign value = data_r;

endmodule
